### rtl/slf_pkg.sv
// ----------------------------------------------------------------------------
// slf_pkg - shared definitions for the sliding-window line-fit predictor
// Default sizes, item mode codes, sequencer states and the status bundle
// that the serial arithmetic units report to the sequencer.
// ----------------------------------------------------------------------------
package slf_pkg;

   localparam int WINDOW_SIZE_DEF = 3;
   localparam int DATA_WIDTH_DEF  = 48;
   localparam int FRAC_BITS_DEF   = 24;

   localparam logic MODE_UPDATE  = 1'b0;
   localparam logic MODE_PREDICT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM_TT,
      ST_SUM_TX,
      ST_DET_A,
      ST_DET_B,
      ST_NUM_A,
      ST_NUM_B,
      ST_DIV_S,
      ST_IC_A,
      ST_IC_B,
      ST_DIV_I,
      ST_PRED,
      ST_PSAT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

### rtl/slf_mul.sv
// ----------------------------------------------------------------------------
// slf_mul - serial signed multiplier
// Consumes one multiplier bit per cycle; the top bit carries negative weight.
// The product is taken modulo 2^AW, wide enough for every caller.
// ----------------------------------------------------------------------------
module slf_mul #(
   parameter int AW = 160,
   parameter int BW = 51
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [AW-1:0]  a,
   input  logic signed [BW-1:0]  b,
   output slf_pkg::unit_stat_type stat,
   output logic signed [AW-1:0]  prod
);

   localparam int CW = $clog2(BW + 1);

   logic [AW-1:0] a_sh_ff;
   logic [BW-1:0] b_sh_ff;
   logic [AW-1:0] acc_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [AW-1:0] term;
   logic          last;
   logic [AW-1:0] acc_in;

   assign term   = b_sh_ff[0] ? a_sh_ff : '0;
   assign last   = (cnt_ff == CW'(1));
   assign acc_in = last ? (acc_ff - term) : (acc_ff + term);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            a_sh_ff <= a;
            b_sh_ff <= b;
            acc_ff  <= '0;
            cnt_ff  <= CW'(BW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            acc_ff  <= acc_in;
            a_sh_ff <= {a_sh_ff[AW-2:0], 1'b0};
            b_sh_ff <= {1'b0, b_sh_ff[BW-1:1]};
            cnt_ff  <= cnt_ff - CW'(1);
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign prod      = acc_ff;

endmodule

### rtl/slf_div.sv
// ----------------------------------------------------------------------------
// slf_div - serial restoring divider on magnitudes
// One quotient bit per cycle, MSB first; quotient truncates toward zero.
// ----------------------------------------------------------------------------
module slf_div #(
   parameter int W = 160
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [W-1:0]           num,
   input  logic [W-1:0]           den,
   output slf_pkg::unit_stat_type stat,
   output logic [W-1:0]           quot
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff;
   logic [W-1:0]  q_ff;
   logic [W-1:0]  den_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [W:0]    shifted;
   logic [W:0]    trial;

   assign shifted = {rem_ff, q_ff[W-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= '0;
            q_ff    <= num;
            den_ff  <= den;
            cnt_ff  <= CW'(W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // keep the trial remainder when it did not borrow
            if (!trial[W]) begin
               rem_ff <= trial[W-1:0];
               q_ff   <= {q_ff[W-2:0], 1'b1};
            end else begin
               rem_ff <= shifted[W-1:0];
               q_ff   <= {q_ff[W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = q_ff;

endmodule

### rtl/sliding_window_line_fit_predictor_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_line_fit_predictor_unit - windowed least-squares line fit
// Keeps the last WINDOW_SIZE (time, value) samples and refits
// value = slope*time + intercept on every update once the window is full;
// a predict item evaluates the current line at a query time.
//
//   channel | ports  | direction | carries
//   --------+--------+-----------+------------------------------------------
//   request | req_*  | in        | mode, sample_value, sample_time
//   result  | rsp_*  | out       | prediction, slope, intercept, flags
//
// One item at a time. All products go through one serial multiplier
// (multiplier operand SW = DATA_WIDTH+clog2(WINDOW_SIZE)+1 bits wide), both quotients
// through one serial divider (W = 3*DATA_WIDTH+FRAC_BITS+8 bits wide).
// A non-singular refit runs 2*WINDOW_SIZE+6 products and both quotients, a
// predict one product, an update before the window fills neither.
// Reset clears the sequencer, count and coefficients; no clearing pass.
// A stalled result holds in the output register; the next item is accepted
// while it waits, and the sequencer stalls only at its own hand-off.
// ----------------------------------------------------------------------------
module sliding_window_line_fit_predictor_unit #(
   parameter int WINDOW_SIZE = slf_pkg::WINDOW_SIZE_DEF,
   parameter int DATA_WIDTH  = slf_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS   = slf_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_mode,
   input  logic signed [DATA_WIDTH-1:0] req_sample_value,
   input  logic signed [DATA_WIDTH-1:0] req_sample_time,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_prediction,
   output logic signed [DATA_WIDTH-1:0] rsp_slope,
   output logic signed [DATA_WIDTH-1:0] rsp_intercept,
   output logic                         rsp_fit_valid,
   output logic                         rsp_singular_flag,
   output logic                         rsp_saturated_flag
);

   localparam int DW    = DATA_WIDTH;
   localparam int IDX_W = $clog2(WINDOW_SIZE);
   localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
   localparam int SW    = DATA_WIDTH + $clog2(WINDOW_SIZE) + 1;
   localparam int W     = 3 * DATA_WIDTH + FRAC_BITS + 8;

   // saturation bounds as magnitudes in the wide domain
   localparam logic [W-1:0] MAX_MAG = {{(W-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic [W-1:0] MIN_MAG = {{(W-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

   slf_pkg::state_type state_ff, state_in;

   // sample window, entry 0 newest
   logic signed [DW-1:0] win_time_ff  [WINDOW_SIZE];
   logic signed [DW-1:0] win_value_ff [WINDOW_SIZE];
   logic [CNT_W-1:0]     count_ff;
   logic [IDX_W-1:0]     idx_ff;

   logic signed [DW-1:0] fit_slope_ff;
   logic signed [DW-1:0] fit_ic_ff;
   logic                 fit_done_ff;

   logic signed [DW-1:0] time_ff;
   logic                 go_ff;
   logic                 sing_ff;
   logic                 sat_ff;
   logic signed [DW-1:0] pred_ff;

   // running sums and intermediate terms
   logic signed [SW-1:0] st_ff;
   logic signed [SW-1:0] sx_ff;
   logic signed [W-1:0]  stt_ff;
   logic signed [W-1:0]  stx_ff;
   logic signed [W-1:0]  p1_ff;
   logic signed [W-1:0]  det_ff;
   logic signed [W-1:0]  num_ff;

   logic                 rsp_valid_ff;
   logic signed [DW-1:0] rsp_pred_ff;
   logic signed [DW-1:0] rsp_slope_ff;
   logic signed [DW-1:0] rsp_ic_ff;
   logic                 rsp_fit_ff;
   logic                 rsp_sing_ff;
   logic                 rsp_sat_ff;

   // unit hookup
   slf_pkg::unit_stat_type mul_stat;
   slf_pkg::unit_stat_type div_stat;
   logic                 mul_start;
   logic                 div_start;
   logic signed [W-1:0]  mul_a;
   logic signed [SW-1:0] mul_b;
   logic signed [W-1:0]  mul_prod;
   logic [W-1:0]         div_num;
   logic [W-1:0]         div_den;
   logic [W-1:0]         div_quot;

   logic                 accept;
   logic                 step;
   logic                 full_after;
   logic                 out_fire;
   logic                 det_zero;
   logic signed [DW-1:0] t_k;
   logic signed [DW-1:0] x_k;
   logic signed [W-1:0]  t_w;
   logic signed [SW-1:0] t_b;
   logic signed [SW-1:0] x_b;
   logic signed [W-1:0]  st_w;
   logic signed [W-1:0]  ic_shift;
   logic signed [W-1:0]  diff;
   logic [W-1:0]         p_abs;
   logic [W-1:0]         sat_mag;
   logic                 sat_neg;
   logic                 sat_over;
   logic signed [DW-1:0] sat_val;

   assign accept     = req_valid && req_ready;
   assign step       = go_ff && (mul_stat.done || div_stat.done);
   assign full_after = (count_ff >= CNT_W'(WINDOW_SIZE - 1));
   assign out_fire   = !rsp_valid_ff || rsp_ready;
   assign det_zero   = (det_ff == '0);

   assign t_k      = win_time_ff[idx_ff];
   assign x_k      = win_value_ff[idx_ff];
   assign t_w      = {{(W-DW){t_k[DW-1]}}, t_k};
   assign t_b      = {{(SW-DW){t_k[DW-1]}}, t_k};
   assign x_b      = {{(SW-DW){x_k[DW-1]}}, x_k};
   assign st_w     = {{(W-SW){st_ff[SW-1]}}, st_ff};
   assign ic_shift = {{(W-DW-FRAC_BITS){fit_ic_ff[DW-1]}}, fit_ic_ff, {FRAC_BITS{1'b0}}};
   assign diff     = p1_ff - mul_prod;

   // magnitudes for the divider; the quotient sign is applied at saturation
   assign div_num = num_ff[W-1] ? W'(-num_ff) : num_ff;
   assign div_den = det_ff[W-1] ? W'(-det_ff) : det_ff;

   // prediction truncates toward zero: shift the magnitude
   assign p_abs = p1_ff[W-1] ? W'(-p1_ff) : p1_ff;

   // shared clamp to the signed field range
   always_comb begin
      if (state_ff == slf_pkg::ST_PSAT) begin
         sat_neg = p1_ff[W-1];
         sat_mag = p_abs >> FRAC_BITS;
      end else begin
         sat_neg = num_ff[W-1] ^ det_ff[W-1];
         sat_mag = div_quot;
      end
      sat_over = sat_neg ? (sat_mag > MIN_MAG) : (sat_mag > MAX_MAG);
      if (sat_over) begin
         sat_val = sat_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
         sat_val = sat_neg ? -sat_mag[DW-1:0] : sat_mag[DW-1:0];
      end
   end

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         slf_pkg::ST_SUM_TT: begin
            mul_a = t_w;
            mul_b = t_b;
         end
         slf_pkg::ST_SUM_TX: begin
            mul_a = t_w;
            mul_b = x_b;
         end
         slf_pkg::ST_DET_A: begin
            mul_a = stt_ff;
            mul_b = SW'(WINDOW_SIZE);
         end
         slf_pkg::ST_DET_B: begin
            mul_a = st_w;
            mul_b = st_ff;
         end
         slf_pkg::ST_NUM_A: begin
            mul_a = stx_ff;
            mul_b = SW'(WINDOW_SIZE);
         end
         slf_pkg::ST_NUM_B: begin
            mul_a = st_w;
            mul_b = sx_ff;
         end
         slf_pkg::ST_IC_A: begin
            mul_a = stt_ff;
            mul_b = sx_ff;
         end
         slf_pkg::ST_IC_B: begin
            mul_a = stx_ff;
            mul_b = st_ff;
         end
         slf_pkg::ST_PRED: begin
            mul_a = {{(W-DW){fit_slope_ff[DW-1]}}, fit_slope_ff};
            mul_b = {{(SW-DW){time_ff[DW-1]}}, time_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slf_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == slf_pkg::MODE_PREDICT) begin
                  state_in = slf_pkg::ST_PRED;
               end else if (full_after) begin
                  state_in = slf_pkg::ST_SUM_TT;
               end else begin
                  state_in = slf_pkg::ST_OUT;
               end
            end
         end
         slf_pkg::ST_SUM_TT: if (step) state_in = slf_pkg::ST_SUM_TX;
         slf_pkg::ST_SUM_TX: begin
            if (step) begin
               state_in = (idx_ff == IDX_W'(WINDOW_SIZE - 1)) ? slf_pkg::ST_DET_A
                                                              : slf_pkg::ST_SUM_TT;
            end
         end
         slf_pkg::ST_DET_A: if (step) state_in = slf_pkg::ST_DET_B;
         slf_pkg::ST_DET_B: if (step) state_in = slf_pkg::ST_NUM_A;
         slf_pkg::ST_NUM_A: begin
            if (!go_ff && det_zero) begin
               state_in = slf_pkg::ST_OUT;
            end else if (step) begin
               state_in = slf_pkg::ST_NUM_B;
            end
         end
         slf_pkg::ST_NUM_B: if (step) state_in = slf_pkg::ST_DIV_S;
         slf_pkg::ST_DIV_S: if (step) state_in = slf_pkg::ST_IC_A;
         slf_pkg::ST_IC_A:  if (step) state_in = slf_pkg::ST_IC_B;
         slf_pkg::ST_IC_B:  if (step) state_in = slf_pkg::ST_DIV_I;
         slf_pkg::ST_DIV_I: if (step) state_in = slf_pkg::ST_OUT;
         slf_pkg::ST_PRED:  if (step) state_in = slf_pkg::ST_PSAT;
         slf_pkg::ST_PSAT:  state_in = slf_pkg::ST_OUT;
         slf_pkg::ST_OUT:   if (out_fire) state_in = slf_pkg::ST_IDLE;
         default:           state_in = slf_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: launch each unit once per state
   always_comb begin
      req_ready = 1'b0;
      mul_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         slf_pkg::ST_IDLE: req_ready = 1'b1;
         slf_pkg::ST_SUM_TT, slf_pkg::ST_SUM_TX, slf_pkg::ST_DET_A, slf_pkg::ST_DET_B,
         slf_pkg::ST_NUM_B, slf_pkg::ST_IC_A, slf_pkg::ST_IC_B, slf_pkg::ST_PRED:
            mul_start = !go_ff;
         slf_pkg::ST_NUM_A: mul_start = !go_ff && !det_zero;
         slf_pkg::ST_DIV_S, slf_pkg::ST_DIV_I: div_start = !go_ff;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   slf_mul #(
      .AW (W),
      .BW (SW)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .stat  (mul_stat),
      .prod  (mul_prod)
   );

   slf_div #(
      .W (W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slf_pkg::ST_IDLE;
         go_ff        <= 1'b0;
         count_ff     <= '0;
         fit_slope_ff <= '0;
         fit_ic_ff    <= '0;
         fit_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_SIZE; i++) begin
            win_time_ff[i]  <= '0;
            win_value_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;

         // hold the launch mark until the unit reports done
         if (mul_start || div_start) begin
            go_ff <= 1'b1;
         end else if (step) begin
            go_ff <= 1'b0;
         end

         // raise on hand-off, drop once the receiver takes the item
         if (state_ff == slf_pkg::ST_OUT && out_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            slf_pkg::ST_IDLE: begin
               if (accept) begin
                  time_ff <= req_sample_time;
                  sing_ff <= 1'b0;
                  sat_ff  <= 1'b0;
                  pred_ff <= '0;
                  idx_ff  <= '0;
                  st_ff   <= '0;
                  sx_ff   <= '0;
                  stt_ff  <= '0;
                  stx_ff  <= '0;
                  if (req_mode == slf_pkg::MODE_UPDATE) begin
                     // advance the window, drop the oldest sample
                     for (int i = WINDOW_SIZE - 1; i > 0; i--) begin
                        win_time_ff[i]  <= win_time_ff[i-1];
                        win_value_ff[i] <= win_value_ff[i-1];
                     end
                     win_time_ff[0]  <= req_sample_time;
                     win_value_ff[0] <= req_sample_value;
                     if (count_ff != CNT_W'(WINDOW_SIZE)) begin
                        count_ff <= count_ff + CNT_W'(1);
                     end
                  end
               end
            end
            slf_pkg::ST_SUM_TT: if (step) stt_ff <= stt_ff + mul_prod;
            slf_pkg::ST_SUM_TX: begin
               if (step) begin
                  stx_ff <= stx_ff + mul_prod;
                  st_ff  <= st_ff + t_b;
                  sx_ff  <= sx_ff + x_b;
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            slf_pkg::ST_DET_A: if (step) p1_ff <= mul_prod;
            slf_pkg::ST_DET_B: if (step) det_ff <= diff;
            slf_pkg::ST_NUM_A: begin
               // equal times: keep the old line and flag it
               if (!go_ff && det_zero) begin
                  sing_ff <= 1'b1;
               end
               if (step) p1_ff <= mul_prod;
            end
            slf_pkg::ST_NUM_B: if (step) num_ff <= diff <<< FRAC_BITS;
            slf_pkg::ST_DIV_S: begin
               if (step) begin
                  fit_slope_ff <= sat_val;
                  sat_ff       <= sat_ff | sat_over;
               end
            end
            slf_pkg::ST_IC_A: if (step) p1_ff <= mul_prod;
            slf_pkg::ST_IC_B: if (step) num_ff <= diff;
            slf_pkg::ST_DIV_I: begin
               if (step) begin
                  fit_ic_ff   <= sat_val;
                  sat_ff      <= sat_ff | sat_over;
                  fit_done_ff <= 1'b1;
               end
            end
            slf_pkg::ST_PRED: if (step) p1_ff <= mul_prod + ic_shift;
            slf_pkg::ST_PSAT: begin
               pred_ff <= sat_val;
               sat_ff  <= sat_over;
            end
            slf_pkg::ST_OUT: begin
               if (out_fire) begin
                  rsp_pred_ff  <= pred_ff;
                  rsp_slope_ff <= fit_slope_ff;
                  rsp_ic_ff    <= fit_ic_ff;
                  rsp_fit_ff   <= fit_done_ff;
                  rsp_sing_ff  <= sing_ff;
                  rsp_sat_ff   <= sat_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_prediction     = rsp_pred_ff;
   assign rsp_slope          = rsp_slope_ff;
   assign rsp_intercept      = rsp_ic_ff;
   assign rsp_fit_valid      = rsp_fit_ff;
   assign rsp_singular_flag  = rsp_sing_ff;
   assign rsp_saturated_flag = rsp_sat_ff;

`ifndef SYNTHESIS
   // one unit runs at a time
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_stat.busy && div_stat.busy))
      else $error("multiplier and divider busy together");

   // a new result appears only from the hand-off state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == slf_pkg::ST_OUT))
      else $error("result raised outside hand-off");

   // an accepted item closes the request side until it is done
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second item accepted while busy");

   // a singular refit computes no coefficients, so nothing can clamp
   a_sing_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular_flag |-> !rsp_saturated_flag)
      else $error("singular and saturated together");
`endif

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the sliding-window line-fit predictor
// Drives update and predict items over a valid/ready channel. An in-bench
// least-squares model predicts the untyped results, and each result is checked
// field by field in order. A directed table covers reset state, extremes,
// equal times and saturation. Random traffic then follows, with idle bursts
// on both sides, one long output stall and one drain pause.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DW = slf_pkg::DATA_WIDTH_DEF;
   localparam int FB = slf_pkg::FRAC_BITS_DEF;
   localparam int NUM_RANDOM = 400;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int LONG_HOLD = 4000;
   localparam int DRAIN_WAIT = 2000;
   localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] ONE = 48'd1 << FB;

   typedef struct packed {
      logic [DW-1:0] prediction;
      logic [DW-1:0] slope;
      logic [DW-1:0] intercept;
      logic          fit_valid;
      logic          singular;
      logic          saturated;
   } fit_result_type;

   typedef struct {
      logic           mode;
      logic [DW-1:0]  value;
      logic [DW-1:0]  tstamp;
      bit             typed;
      fit_result_type res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = slf_pkg::MODE_UPDATE;
   logic signed [DW-1:0] req_sample_value = '0;
   logic signed [DW-1:0] req_sample_time = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [DW-1:0] rsp_prediction;
   logic signed [DW-1:0] rsp_slope;
   logic signed [DW-1:0] rsp_intercept;
   logic rsp_fit_valid;
   logic rsp_singular_flag;
   logic rsp_saturated_flag;

   // line model state
   logic signed [DW-1:0] win_time[3];
   logic signed [DW-1:0] win_value[3];
   int unsigned          win_fill;
   logic signed [DW-1:0] cur_slope;
   logic signed [DW-1:0] cur_icpt;
   logic                 cur_done;

   fit_result_type expected_fits[$];
   bit             cur_typed = 0;
   fit_result_type cur_typed_res;
   bit          quiet = 0;
   bit          long_hold_req = 0;
   bit          no_gap = 0;
   int unsigned errors = 0;
   int unsigned cycles = 0;
   int unsigned n_update = 0, n_predict = 0, n_singular = 0, n_saturated = 0;

   sliding_window_line_fit_predictor_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clamp a wide value to the signed data range; flag a clamp.
   function automatic logic [DW-1:0] clamp_dw(input logic signed [255:0] v, inout logic sat);
      logic signed [255:0] hi, lo;
      hi = $signed({1'b0, VMAX});
      lo = -hi - 1;
      if (v > hi) begin
         sat = 1'b1;
         return VMAX;
      end
      if (v < lo) begin
         sat = 1'b1;
         return VMIN;
      end
      return v[DW-1:0];
   endfunction

   // Advance the line model by one item and return the result it gives.
   function automatic fit_result_type line_fit_step(input logic mode, input logic [DW-1:0] val,
                                                    input logic [DW-1:0] tim);
      fit_result_type r;
      logic signed [255:0] st, sx, stt, stx, det, num, icn, p, a, b;
      logic sat;
      r = '0;
      sat = 1'b0;
      if (mode == slf_pkg::MODE_UPDATE) begin
         win_time[2] = win_time[1];
         win_value[2] = win_value[1];
         win_time[1] = win_time[0];
         win_value[1] = win_value[0];
         win_time[0] = tim;
         win_value[0] = val;
         if (win_fill < 3) win_fill++;
         if (win_fill == 3) begin
            st = 0; sx = 0; stt = 0; stx = 0;
            for (int i = 0; i < 3; i++) begin
               a = win_time[i];
               b = win_value[i];
               st += a;
               sx += b;
               stt += a * a;
               stx += a * b;
            end
            det = 3 * stt - st * st;
            if (det == 0) begin
               r.singular = 1'b1;
            end else begin
               num = (3 * stx - st * sx) <<< FB;
               icn = stt * sx - st * stx;
               cur_slope = clamp_dw(num / det, sat);
               cur_icpt = clamp_dw(icn / det, sat);
               cur_done = 1'b1;
            end
         end
      end else begin
         a = cur_slope;
         b = $signed(tim);
         p = cur_icpt;
         p = a * b + (p <<< FB);
         a = 256'sd1 <<< FB;
         r.prediction = clamp_dw(p / a, sat);
      end
      r.slope = cur_slope;
      r.intercept = cur_icpt;
      r.fit_valid = cur_done;
      r.saturated = sat;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [DW-1:0] exp_v,
                              input logic [DW-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // Predict on accepted items, check accepted results against the oldest entry.
   always @(posedge clock) begin
      fit_result_type e, m;
      cycles++;
      if (!reset && req_valid && req_ready) begin
         m = line_fit_step(req_mode, req_sample_value, req_sample_time);
         expected_fits.push_back(cur_typed ? cur_typed_res : m);
         if (req_mode == slf_pkg::MODE_UPDATE) n_update++;
         else n_predict++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_fits.size() == 0) begin
            $error("result arrived with no item outstanding");
            errors++;
         end else begin
            e = expected_fits.pop_front();
            check_field("prediction", e.prediction, rsp_prediction);
            check_field("slope", e.slope, rsp_slope);
            check_field("intercept", e.intercept, rsp_intercept);
            check_field("fit_valid", e.fit_valid, rsp_fit_valid);
            check_field("singular_flag", e.singular, rsp_singular_flag);
            check_field("saturated_flag", e.saturated, rsp_saturated_flag);
            if (rsp_singular_flag) n_singular++;
            if (rsp_saturated_flag) n_saturated++;
         end
      end
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result side: random ready bursts, one long hold-off, steady when quiet.
   initial begin
      int unsigned len;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_ready <= 1'b0;
            len = 0;
            while (len < LONG_HOLD) begin
               @(negedge clock);
               len++;
            end
            long_hold_req = 0;
         end else if (quiet) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 2) != 0);
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
      end
   end

   task automatic send_item(input logic mode, input logic [DW-1:0] val,
                            input logic [DW-1:0] tim, input bit typed,
                            input fit_result_type tres);
      if (!quiet && !no_gap && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_sample_value <= val;
      req_sample_time <= tim;
      cur_typed = typed;
      cur_typed_res = tres;
      // hold until accepted
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [DW-1:0] rand_dw();
      return DW'({$urandom, $urandom});
   endfunction

   initial begin
      stim_row_type   table_rows[$];
      fit_result_type zero_res, sing_res;
      logic [DW-1:0] t_now, val, tim;
      logic          mode;
      int unsigned   k, wait_n;

      win_time = '{default: '0};
      win_value = '{default: '0};
      win_fill = 0;
      cur_slope = '0;
      cur_icpt = '0;
      cur_done = 1'b0;
      zero_res = '0;
      sing_res = '0;
      sing_res.singular = 1'b1;

      // Directed rows: reset state, extremes, equal times, saturation, exact fit.
      table_rows = '{
         '{slf_pkg::MODE_PREDICT, VMAX, VMAX, 1, zero_res},
         '{slf_pkg::MODE_UPDATE,  VMAX, VMAX, 1, zero_res},
         '{slf_pkg::MODE_UPDATE,  VMIN, VMAX, 1, zero_res},
         '{slf_pkg::MODE_UPDATE,  '0,   VMAX, 1, sing_res},
         '{slf_pkg::MODE_PREDICT, '0,   VMIN, 1, zero_res},
         '{slf_pkg::MODE_UPDATE,  VMIN, '0,   0, zero_res},
         '{slf_pkg::MODE_UPDATE,  VMAX, 48'd1, 0, zero_res},
         '{slf_pkg::MODE_UPDATE,  VMIN, 48'd2, 0, zero_res},
         '{slf_pkg::MODE_PREDICT, '0,   VMAX, 0, zero_res},
         '{slf_pkg::MODE_PREDICT, VMAX, VMIN, 0, zero_res},
         '{slf_pkg::MODE_PREDICT, '0,   '0,   0, zero_res},
         '{slf_pkg::MODE_UPDATE,  ONE,      ONE,      0, zero_res},
         '{slf_pkg::MODE_UPDATE,  2 * ONE,  2 * ONE,  0, zero_res},
         '{slf_pkg::MODE_UPDATE,  3 * ONE,  3 * ONE,  0, zero_res},
         '{slf_pkg::MODE_PREDICT, '0,   10 * ONE, 0, zero_res},
         '{slf_pkg::MODE_UPDATE,  5 * ONE,  3 * ONE,  0, zero_res},
         '{slf_pkg::MODE_UPDATE,  7 * ONE,  3 * ONE,  0, zero_res},
         '{slf_pkg::MODE_UPDATE,  -ONE,     VMIN,     0, zero_res},
         '{slf_pkg::MODE_UPDATE,  VMAX,     VMAX,     0, zero_res},
         '{slf_pkg::MODE_UPDATE,  VMIN,     -ONE,     0, zero_res},
         '{slf_pkg::MODE_PREDICT, VMIN, VMAX, 0, zero_res},
         '{slf_pkg::MODE_PREDICT, '0,   -ONE, 0, zero_res}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (table_rows[i])
         send_item(table_rows[i].mode, table_rows[i].value, table_rows[i].tstamp,
                   table_rows[i].typed, table_rows[i].res);

      // Random traffic: mostly well-formed streams of rising times.
      t_now = rand_dw() >>> 8;
      for (k = 0; k < NUM_RANDOM; k++) begin
         if (k == 100) begin
            // stall the output for a long stretch while items keep coming
            long_hold_req = 1;
            no_gap = 1;
         end
         if (k == 130) no_gap = 0;
         if (k == 220) begin
            // pause the sender until every result is back
            req_valid <= 1'b0;
            @(negedge clock);
            while (expected_fits.size() != 0) @(negedge clock);
         end
         if (k == NUM_RANDOM - 60) quiet = 1;
         mode = ($urandom_range(0, 3) == 0) ? slf_pkg::MODE_PREDICT : slf_pkg::MODE_UPDATE;
         case ($urandom_range(0, 9))
            0, 1:    val = rand_dw();
            2:       val = $urandom_range(0, 1) ? VMAX : VMIN;
            default: val = {{16{$urandom_range(0, 1) ? 1'b1 : 1'b0}}, $urandom};
         endcase
         case ($urandom_range(0, 11))
            0:       tim = rand_dw();
            1:       tim = t_now;
            2:       tim = $urandom_range(0, 1) ? VMAX : VMIN;
            default: begin
               t_now = t_now + $urandom_range(1, 1 << 26);
               tim = t_now;
            end
         endcase
         send_item(mode, val, tim, 0, zero_res);
      end
      req_valid <= 1'b0;

      // Drain, then give the block time to show any stray result.
      while (expected_fits.size() != 0) @(negedge clock);
      wait_n = 0;
      while (wait_n < DRAIN_WAIT) begin
         @(negedge clock);
         wait_n++;
      end
      if (expected_fits.size() != 0) begin
         $error("%0d results never arrived", expected_fits.size());
         errors++;
      end

      $display("covered %0d updates and %0d predictions in %0d cycles",
               n_update, n_predict, cycles);
      $display("results with equal-time refits: %0d, with clamping: %0d",
               n_singular, n_saturated);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
